// File: hw/rtl/barometric_pressure_compensation_defines.svh
// Assertion macros for the barometric pressure compensation block.
`ifndef BAROMETRIC_PRESSURE_COMPENSATION_DEFINES_SVH
`define BAROMETRIC_PRESSURE_COMPENSATION_DEFINES_SVH
`ifndef SYNTHESIS
`define BPC_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
`define BPC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define BPC_ASSERT_SAME(lbl, ante, cons, msg)
`define BPC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: hw/rtl/bpc_pkg.sv
// Shared types and constants for the barometric pressure compensation block.
package bpc_pkg;
	localparam int unsigned CalWords = 11;

	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_TEMP  = 2'd1;
	localparam logic [1:0] OP_PRESS = 2'd2;
	localparam logic [1:0] OP_NONE  = 2'd3;

	localparam logic [1:0] ST_VALID   = 2'd0;
	localparam logic [1:0] ST_STORED  = 2'd1;
	localparam logic [1:0] ST_DIVZERO = 2'd2;

	typedef struct packed {
		logic        start;
		logic        sgn;
		logic [31:0] num;
		logic [31:0] den;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] quo;
	} div_rsp_t;
endpackage

// File: hw/rtl/bpc_div.sv
// Iterative 32-bit restoring divider, signed or unsigned, one quotient bit per cycle.
module bpc_div (
	input  logic              clk,
	input  logic              arst_n,
	input  bpc_pkg::div_req_t req,
	output bpc_pkg::div_rsp_t rsp
);
	logic        busy_q;
	logic        done_q;
	logic        neg_q;
	logic [4:0]  cnt_q;
	logic [31:0] rem_q;
	logic [31:0] quo_q;
	logic [31:0] den_q;
	logic [31:0] num_mag;
	logic [31:0] den_mag;
	logic [32:0] rem_sh;
	logic [32:0] diff;

	assign num_mag = (req.sgn && req.num[31]) ? (32'd0 - req.num) : req.num;
	assign den_mag = (req.sgn && req.den[31]) ? (32'd0 - req.den) : req.den;
	assign rem_sh  = {rem_q, quo_q[31]};
	assign diff    = rem_sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= num_mag;
			den_q <= den_mag;
			neg_q <= req.sgn & (req.num[31] ^ req.den[31]);
		end else if (busy_q) begin
			if (!diff[32]) begin
				rem_q <= diff[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= rem_sh[31:0];
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = neg_q ? (32'd0 - quo_q) : quo_q;
endmodule

// File: hw/rtl/barometric_pressure_compensation.sv
// Barometric compensation: one shared multiplier and divider under a step sequencer.
// A load or unused op goes straight to the finish state; temperature runs one multiply and one divide;
// pressure runs eleven multiplies and two divides, ending early in the finish state if a divisor is zero.
// One request at a time; in_ready returns with the result, which waits in the finish state while an
// earlier result is still untaken; the divider's one bit per cycle sets the pace.
// Reset clears the calibration table, stored temperature, state, step and output-valid registers.
`include "barometric_pressure_compensation_defines.svh"
module barometric_pressure_compensation (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         op,
	input  logic [3:0]         cal_index,
	input  logic [15:0]        cal_value,
	input  logic [23:0]        raw_sample,
	input  logic [1:0]         oversampling,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] result_value,
	output logic [1:0]         status
);
	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_MUL   = 6'b000010,
		S_WB    = 6'b000100,
		S_DIV   = 6'b001000,
		S_DWAIT = 6'b010000,
		S_FIN   = 6'b100000
	} state_t;

	typedef enum logic [10:0] {
		K_T   = 11'b00000000001,
		K_SQ  = 11'b00000000010,
		K_X1A = 11'b00000000100,
		K_X2A = 11'b00000001000,
		K_X1B = 11'b00000010000,
		K_X2B = 11'b00000100000,
		K_B4  = 11'b00001000000,
		K_B7  = 11'b00010000000,
		K_PP  = 11'b00100000000,
		K_C1  = 11'b01000000000,
		K_C2  = 11'b10000000000
	} step_t;

	state_t state_q;
	step_t  step_q;

	logic [15:0] cal_q [bpc_pkg::CalWords];
	logic [15:0] ut_q;
	logic [23:0] raw_q;
	logic [1:0]  oss_q;
	logic        press_q;
	logic        divk_q;
	logic        dbl_q;

	logic signed [31:0] prod_q, x1_q, b6_q, sq_q, t_q, b3_q, b4_q, pv_q;
	logic [31:0] dnum_q, dden_q;
	logic        dsgn_q;
	logic signed [31:0] fin_val_q;
	logic [1:0]  fin_st_q;
	logic        ov_q;
	logic signed [31:0] res_q;
	logic [1:0]  st_q;

	logic signed [31:0] cs [bpc_pkg::CalWords];
	logic signed [31:0] opa, opb;
	logic [31:0] full;
	logic signed [31:0] up, den_t, x3a, va, b3n, x3b, b5, tval, pval, q2, b7sh;
	logic [31:0] b4n;

	bpc_pkg::div_req_t dreq;
	bpc_pkg::div_rsp_t drsp;

	bpc_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	assign dreq.start = (state_q == S_DIV);
	assign dreq.sgn   = dsgn_q;
	assign dreq.num   = dnum_q;
	assign dreq.den   = dden_q;

	always_comb begin
		for (int i = 0; i < bpc_pkg::CalWords; i++) begin
			cs[i] = {{16{cal_q[i][15]}}, cal_q[i]};
		end
	end

	assign up = $signed({8'd0, raw_q >> (5'd8 - {3'd0, oss_q})});

	always_comb begin
		case (step_q)
			K_T:   begin opa = $signed({16'd0, ut_q}) - $signed({16'd0, cal_q[5]});
				opb = $signed({16'd0, cal_q[4]}); end
			K_SQ:  begin opa = b6_q; opb = b6_q; end
			K_X1A: begin opa = cs[7]; opb = sq_q; end
			K_X2A: begin opa = cs[1]; opb = b6_q; end
			K_X1B: begin opa = cs[2]; opb = b6_q; end
			K_X2B: begin opa = cs[6]; opb = sq_q; end
			K_B4:  begin opa = $signed({16'd0, cal_q[3]}); opb = t_q; end
			K_B7:  begin opa = up - b3_q; opb = $signed(32'd50000 >> oss_q); end
			K_PP:  begin opa = pv_q >>> 8; opb = pv_q >>> 8; end
			K_C1:  begin opa = t_q; opb = 32'sd3038; end
			K_C2:  begin opa = -32'sd7357; opb = pv_q; end
			default: begin opa = '0; opb = '0; end
		endcase
	end

	assign full  = $unsigned(opa) * $unsigned(opb);
	assign den_t = (prod_q >>> 15) + cs[10];
	assign x3a   = t_q + (prod_q >>> 11);
	assign va    = (((cs[0] <<< 2) + x3a) <<< oss_q) + 32'sd2;
	assign b3n   = (va + (va[31] ? 32'sd3 : 32'sd0)) >>> 2;
	assign x3b   = ((t_q + (prod_q >>> 16)) + 32'sd2) >>> 2;
	assign b4n   = $unsigned(prod_q) >> 15;
	assign b5    = x1_q + $signed(drsp.quo);
	assign tval  = (b5 + 32'sd8) >>> 4;
	assign q2    = dbl_q ? $signed({drsp.quo[30:0], 1'b0}) : $signed(drsp.quo);
	assign pval  = pv_q + (((t_q + (prod_q >>> 16)) + 32'sd3791) >>> 4);
	assign b7sh  = prod_q[31] ? prod_q : (prod_q <<< 1);

	assign in_ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= K_T;
			ov_q    <= 1'b0;
			ut_q    <= '0;
			for (int i = 0; i < bpc_pkg::CalWords; i++) begin
				cal_q[i] <= '0;
			end
		end else begin
			if (ov_q && out_ready && (state_q != S_FIN)) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						step_q <= K_T;
						case (op)
							bpc_pkg::OP_LOAD: begin
								if (cal_index < 4'(bpc_pkg::CalWords)) begin
									cal_q[cal_index] <= cal_value;
								end
								state_q <= S_FIN;
							end
							bpc_pkg::OP_TEMP: begin
								ut_q    <= raw_sample[15:0];
								state_q <= S_MUL;
							end
							bpc_pkg::OP_PRESS: state_q <= S_MUL;
							default: state_q <= S_FIN;
						endcase
					end
				end
				S_MUL: state_q <= S_WB;
				S_WB: begin
					case (step_q)
						K_T:   state_q <= (den_t == 32'sd0) ? S_FIN : S_DIV;
						K_SQ:  begin step_q <= K_X1A; state_q <= S_MUL; end
						K_X1A: begin step_q <= K_X2A; state_q <= S_MUL; end
						K_X2A: begin step_q <= K_X1B; state_q <= S_MUL; end
						K_X1B: begin step_q <= K_X2B; state_q <= S_MUL; end
						K_X2B: begin step_q <= K_B4; state_q <= S_MUL; end
						K_B4: begin
							if (b4n == 32'd0) begin
								state_q <= S_FIN;
							end else begin
								step_q  <= K_B7;
								state_q <= S_MUL;
							end
						end
						K_B7:  state_q <= S_DIV;
						K_PP:  begin step_q <= K_C1; state_q <= S_MUL; end
						K_C1:  begin step_q <= K_C2; state_q <= S_MUL; end
						K_C2:  state_q <= S_FIN;
						default: state_q <= S_FIN;
					endcase
				end
				S_DIV: state_q <= S_DWAIT;
				S_DWAIT: begin
					if (drsp.done) begin
						if (!divk_q && !press_q) begin
							state_q <= S_FIN;
						end else begin
							state_q <= S_MUL;
							step_q  <= divk_q ? K_PP : K_SQ;
						end
					end
				end
				S_FIN: begin
					if (!ov_q || out_ready) begin
						ov_q    <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				raw_q     <= raw_sample;
				oss_q     <= oversampling;
				press_q   <= (op == bpc_pkg::OP_PRESS);
				fin_val_q <= '0;
				fin_st_q  <= (op == bpc_pkg::OP_LOAD) ? bpc_pkg::ST_STORED : bpc_pkg::ST_VALID;
			end
			S_MUL: prod_q <= $signed(full[31:0]);
			S_WB: begin
				case (step_q)
					K_T: begin
						x1_q     <= prod_q >>> 15;
						dnum_q   <= $unsigned(cs[9] <<< 11);
						dden_q   <= $unsigned(den_t);
						dsgn_q   <= 1'b1;
						divk_q   <= 1'b0;
						fin_st_q <= bpc_pkg::ST_DIVZERO;
					end
					K_SQ:  sq_q <= prod_q >>> 12;
					K_X1A: t_q <= prod_q >>> 11;
					K_X2A: b3_q <= b3n;
					K_X1B: t_q <= prod_q >>> 13;
					K_X2B: t_q <= x3b + 32'sd32768;
					K_B4: begin
						b4_q     <= $signed(b4n);
						fin_st_q <= bpc_pkg::ST_DIVZERO;
					end
					K_B7: begin
						dnum_q <= $unsigned(b7sh);
						dden_q <= $unsigned(b4_q);
						dsgn_q <= 1'b0;
						divk_q <= 1'b1;
						dbl_q  <= prod_q[31];
					end
					K_PP:  t_q <= prod_q;
					K_C1:  t_q <= prod_q >>> 16;
					K_C2: begin
						fin_val_q <= pval;
						fin_st_q  <= bpc_pkg::ST_VALID;
					end
					default: t_q <= t_q;
				endcase
			end
			S_DWAIT: begin
				if (drsp.done) begin
					fin_st_q <= bpc_pkg::ST_VALID;
					if (divk_q) begin
						pv_q <= q2;
					end else begin
						b6_q      <= b5 - 32'sd4000;
						fin_val_q <= press_q ? 32'sd0 : tval;
					end
				end
			end
			S_FIN: begin
				if (!ov_q || out_ready) begin
					res_q <= fin_val_q;
					st_q  <= fin_st_q;
				end
			end
			default: prod_q <= prod_q;
		endcase
	end

	assign out_valid    = ov_q;
	assign result_value = res_q;
	assign status       = st_q;

	`BPC_ASSERT_NEXT(a_accept_busy, in_valid && in_ready, state_q != S_IDLE, "accepted request left block idle")
	`BPC_ASSERT_SAME(a_div_nonzero, dreq.start, dreq.den != 32'd0, "divider started with zero divisor")
	`BPC_ASSERT_NEXT(a_fin_out, (state_q == S_FIN) && (!ov_q || out_ready), ov_q, "finished result not presented")
endmodule
